// ===== rtl/qrbv_pkg.sv =====
// qrbv_pkg: shared types and constants for the queue with remove by value
// no dependencies
package qrbv_pkg;

    localparam int QRBV_DEPTH = 4;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

endpackage

// ===== rtl/queue_with_remove_by_value.sv =====
// queue_with_remove_by_value: input register, queue core, result register
// result path: an accepted item waits in the input register until the result register can take its result
// throughput: one item per cycle while the output is not stalled, set by the single-pass update in qrbv_core
// reset: asynchronous active-low rst_n empties the queue and zeroes all entries
// depends on qrbv_pkg and qrbv_core
module queue_with_remove_by_value #(
    parameter int DEPTH = qrbv_pkg::QRBV_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic signed [qrbv_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [qrbv_pkg::STATUS_W-1:0]       status,
    output logic [qrbv_pkg::OCC_W-1:0]          occupancy
);
    import qrbv_pkg::*;

    logic               in_vld_reg;
    logic               kind_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               out_vld_reg;
    status_t            status_reg;
    logic [OCC_W-1:0]   occ_reg;
    logic               advance;
    status_t            core_status;
    logic [OCC_W-1:0]   core_occ;

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    qrbv_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .kind      (kind_reg),
        .value     (value_reg),
        .status    (core_status),
        .occupancy (core_occ)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg  <= kind;
            value_reg <= value;
        end
        if (advance)
        begin
            status_reg <= core_status;
            occ_reg    <= core_occ;
        end
    end

    assign out_valid = out_vld_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

endmodule

// ===== rtl/qrbv_core.sv =====
// qrbv_core: entry registers, count, parallel match and shift update
// depends on qrbv_pkg
module qrbv_core #(
    parameter int DEPTH = qrbv_pkg::QRBV_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  logic                            kind,
    input  logic [qrbv_pkg::VALUE_W-1:0]    value,
    output qrbv_pkg::status_t               status,
    output logic [qrbv_pkg::OCC_W-1:0]      occupancy
);
    import qrbv_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VALUE_W-1:0] entries_reg  [DEPTH];
    logic [VALUE_W-1:0] entries_next [DEPTH];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [DEPTH-1:0]   hit_vec;
    logic [IW-1:0]      pos;
    logic               hit;

    // match nearest the rear
    always_comb
    begin
        pos = '0;
        hit = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_vec[i] = (CW'(i) < count_reg) && (entries_reg[i] == value);
            if (hit_vec[i])
            begin
                pos = IW'(i);
                hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        status       = ST_OK;
        unique case (kind_t'(kind))
            KIND_INSERT:
            begin
                if (count_reg < CW'(DEPTH))
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (CW'(i) == count_reg)
                        begin
                            entries_next[i] = value;
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    status = ST_OVERFLOW;
                end
            end
            KIND_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else if (!hit)
                begin
                    status = ST_NOT_FOUND;
                end
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (IW'(i) >= pos)
                        begin
                            if (i + 1 < DEPTH && CW'(i + 1) < count_reg)
                            begin
                                entries_next[i] = entries_reg[(i + 1) % DEPTH];
                            end
                            else
                            begin
                                entries_next[i] = '0;
                            end
                        end
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    assign occupancy = OCC_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                entries_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            count_reg    <= count_next;
            entries_reg  <= entries_next;
        end
    end

endmodule
